/* rtl/tmr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map renderer package
// Store sizes, request and register codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package tmr_pkg;

    // Tile store size must be a power of two (addresses wrap at its size).
    localparam int TILE_STORE_BYTES = 65536;
    localparam int PALETTE_ENTRIES  = 256;
    localparam int TILE_ADDR_W      = $clog2(TILE_STORE_BYTES);
    localparam int PAL_ADDR_W       = $clog2(PALETTE_ENTRIES);

    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] LAST_POS = 5'd31;

    // Request codes
    localparam logic [1:0] REQ_RENDER = 2'd0;
    localparam logic [1:0] REQ_GFX_WR = 2'd1;
    localparam logic [1:0] REQ_PAL_WR = 2'd2;

    // Register indexes
    localparam logic [1:0] CFG_SINGLE_PAL  = 2'd0;
    localparam logic [1:0] CFG_EIGHT_BPP   = 2'd1;
    localparam logic [1:0] CFG_OPAQUE_ZERO = 2'd2;

    localparam logic [7:0] LO_NIBBLE = 8'h0F;
    localparam logic [7:0] HI_NIBBLE = 8'hF0;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GFX,
        ST_IDX,
        ST_IDX2,
        ST_PAL_L,
        ST_PAL_R,
        ST_EMIT
    } t_state;

    // Result of the shared shading unit
    typedef struct packed {
        logic [PAL_ADDR_W-1:0] pal_addr;
        logic                  transparent;
    } t_shade_res;

endpackage

/* rtl/tmr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module tmr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/tmr_shade_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shading unit
// Add the palette offset to a pixel index and flag transparent index zero.
// ----------------------------------------------------------------------------
module tmr_shade_unit (
    input  logic [7:0]          i_index,
    input  logic [7:0]          i_pal_base,
    input  logic                i_opaque_zero,
    output tmr_pkg::t_shade_res o_res
);
    import tmr_pkg::*;

    logic [7:0] sum;

    // wraps modulo the palette size
    assign sum = i_index + i_pal_base;

    always_comb begin
        o_res.pal_addr    = sum[PAL_ADDR_W-1:0];
        o_res.transparent = (i_index == 8'd0) && !i_opaque_zero;
    end

endmodule

/* rtl/tile_map_pixel_renderer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map pixel renderer
// Expands one 8x8 tile of a screen entry into 32 RGBA pixel pairs.
// ----------------------------------------------------------------------------
// Graphics-byte and palette writes give no result.
// A render transaction expands the addressed tile into 32 pair transactions
// in destination raster order. Each pair goes through a small sequencer:
// one read of the tile store (two in 8bpp), then two palette reads through
// the single palette read port, each passing the shared shading unit, then
// a load into the output register, which waits while the output side
// stalls; the input stalls until the whole render is done. The
// last pair may still wait in the output register while the next
// transaction is accepted. Registers are written only while idle: the
// configuration port is ready only then. Unwritten store entries read as
// undefined data.
// ----------------------------------------------------------------------------
module tile_map_pixel_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_screen_entry,
    input  logic [15:0] i_gfx_addr,
    input  logic [7:0]  i_gfx_byte,
    input  logic [7:0]  i_pal_index,
    input  logic [7:0]  i_pal_red,
    input  logic [7:0]  i_pal_green,
    input  logic [7:0]  i_pal_blue,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_pixel_row,
    output logic [1:0]  o_pair_column,
    output logic [7:0]  o_left_red,
    output logic [7:0]  o_left_green,
    output logic [7:0]  o_left_blue,
    output logic [7:0]  o_left_alpha,
    output logic [7:0]  o_right_red,
    output logic [7:0]  o_right_green,
    output logic [7:0]  o_right_blue,
    output logic [7:0]  o_right_alpha,
    output logic        o_last_pair
);
    import tmr_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_pos;
    logic [15:0]       r_entry;
    logic              r_single_pal, r_eight_bpp, r_opaque_zero;
    logic [7:0]        r_pix0, r_pix1;      // raw left/right index before flip
    logic              r_left_clear, r_right_clear;
    logic [23:0]       r_left_rgb;
    logic              r_out_valid;
    logic [2:0]        r_pixel_row;
    logic [1:0]        r_pair_column;
    logic [31:0]       r_left_px, r_right_px;
    logic              r_last_pair;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_accept, out_take, out_free;
    logic gfx_wr, pal_wr, render_start;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign out_take     = r_out_valid && !i_out_stall;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign gfx_wr       = in_accept && (i_req_type == REQ_GFX_WR);
    assign pal_wr       = in_accept && (i_req_type == REQ_PAL_WR);
    assign render_start = in_accept && (i_req_type == REQ_RENDER);
    // hold register writes off while a render is running
    assign o_cfg_ready  = (r_state == ST_IDLE);

    // ------------------------------------------------------------------
    // Sequencer control
    // ------------------------------------------------------------------
    logic tile_rd_en, tile_rd_odd, cap_first, cap_second;
    logic pal_rd_en, shade_right, load_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (render_start) n_state = ST_GFX;
            ST_GFX:   n_state = ST_IDX;
            ST_IDX:   n_state = r_eight_bpp ? ST_IDX2 : ST_PAL_L;
            ST_IDX2:  n_state = ST_PAL_L;
            ST_PAL_L: n_state = ST_PAL_R;
            ST_PAL_R: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_pos == LAST_POS) ? ST_IDLE : ST_GFX;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        tile_rd_en  = 1'b0;
        tile_rd_odd = 1'b0;
        cap_first   = 1'b0;
        cap_second  = 1'b0;
        pal_rd_en   = 1'b0;
        shade_right = 1'b0;
        load_out    = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_stall = 1'b0;
            ST_GFX:   tile_rd_en = 1'b1;
            ST_IDX: begin
                // fetch the right-hand byte in 8bpp
                cap_first   = 1'b1;
                tile_rd_en  = r_eight_bpp;
                tile_rd_odd = 1'b1;
            end
            ST_IDX2:  cap_second = 1'b1;
            ST_PAL_L: pal_rd_en = 1'b1;
            ST_PAL_R: begin
                pal_rd_en   = 1'b1;
                shade_right = 1'b1;
            end
            ST_EMIT:  load_out = out_free;
            default:  o_in_stall = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Tile store addressing: flips mirror row and pair
    // ------------------------------------------------------------------
    logic        hflip, vflip;
    logic [9:0]  tile;
    logic [2:0]  src_row;
    logic [1:0]  src_col;
    logic [15:0] gfx_rd_addr;
    logic [7:0]  tile_rd_data;

    assign tile    = r_entry[9:0];
    assign hflip   = r_entry[10];
    assign vflip   = r_entry[11];
    assign src_row = r_pos[4:2] ^ {3{vflip}};
    assign src_col = r_pos[1:0] ^ {2{hflip}};
    assign gfx_rd_addr = r_eight_bpp ? {tile, src_row, src_col, tile_rd_odd}
                                     : {1'b0, tile, src_row, src_col};

    tmr_ram #(
        .DATA_W (8),
        .DEPTH  (TILE_STORE_BYTES)
    ) u_tile_store (
        .i_clk     (i_clk),
        .i_wr_en   (gfx_wr),
        .i_wr_addr (i_gfx_addr[TILE_ADDR_W-1:0]),
        .i_wr_data (i_gfx_byte),
        .i_rd_en   (tile_rd_en),
        .i_rd_addr (gfx_rd_addr[TILE_ADDR_W-1:0]),
        .o_rd_data (tile_rd_data)
    );

    // ------------------------------------------------------------------
    // Shared shading unit, left pixel then right pixel
    // ------------------------------------------------------------------
    logic [7:0] left_idx, right_idx, pal_base;
    t_shade_res shade;
    logic [23:0] pal_rd_data;

    // a horizontal flip also swaps the two pixels of a pair
    assign left_idx  = hflip ? r_pix1 : r_pix0;
    assign right_idx = hflip ? r_pix0 : r_pix1;
    assign pal_base  = r_single_pal ? 8'd0 : {r_entry[15:12], 4'd0};

    tmr_shade_unit u_shade (
        .i_index       (shade_right ? right_idx : left_idx),
        .i_pal_base    (pal_base),
        .i_opaque_zero (r_opaque_zero),
        .o_res         (shade)
    );

    tmr_ram #(
        .DATA_W (24),
        .DEPTH  (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (pal_wr),
        .i_wr_addr (i_pal_index[PAL_ADDR_W-1:0]),
        .i_wr_data ({i_pal_red, i_pal_green, i_pal_blue}),
        .i_rd_en   (pal_rd_en),
        .i_rd_addr (shade.pal_addr),
        .o_rd_data (pal_rd_data)
    );

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pos         <= '0;
            r_out_valid   <= 1'b0;
            r_single_pal  <= 1'b0;
            r_eight_bpp   <= 1'b0;
            r_opaque_zero <= 1'b0;
        end else begin
            r_state <= n_state;
            // advance the pair counter as each pair leaves; wraps to zero
            if (load_out) begin
                r_pos <= r_pos + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_SINGLE_PAL:  r_single_pal  <= i_cfg_data;
                    CFG_EIGHT_BPP:   r_eight_bpp   <= i_cfg_data;
                    CFG_OPAQUE_ZERO: r_opaque_zero <= i_cfg_data;
                    default:         ;  // drop writes beyond the register list
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (render_start) begin
            r_entry <= i_screen_entry;
        end
        if (cap_first) begin
            if (r_eight_bpp) begin
                r_pix0 <= tile_rd_data;
            end else begin
                // low nibble is the left pixel
                r_pix0 <= tile_rd_data & LO_NIBBLE;
                r_pix1 <= (tile_rd_data & HI_NIBBLE) >> 4;
            end
        end
        if (cap_second) begin
            r_pix1 <= tile_rd_data;
        end
        if (pal_rd_en && !shade_right) begin
            r_left_clear <= shade.transparent;
        end
        if (shade_right) begin
            r_left_rgb    <= pal_rd_data;
            r_right_clear <= shade.transparent;
        end
        if (load_out) begin
            r_pixel_row   <= r_pos[4:2];
            r_pair_column <= r_pos[1:0];
            r_left_px     <= r_left_clear  ? 32'd0 : {r_left_rgb, ALPHA_OPAQUE};
            r_right_px    <= r_right_clear ? 32'd0 : {pal_rd_data, ALPHA_OPAQUE};
            r_last_pair   <= (r_pos == LAST_POS);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_row   = r_pixel_row;
    assign o_pair_column = r_pair_column;
    assign o_left_red    = r_left_px[31:24];
    assign o_left_green  = r_left_px[23:16];
    assign o_left_blue   = r_left_px[15:8];
    assign o_left_alpha  = r_left_px[7:0];
    assign o_right_red   = r_right_px[31:24];
    assign o_right_green = r_right_px[23:16];
    assign o_right_blue  = r_right_px[15:8];
    assign o_right_alpha = r_right_px[7:0];
    assign o_last_pair   = r_last_pair;

`ifndef NO_ASSERTIONS
    // Pair counter sits at zero whenever no render is in flight.
    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pos == '0))
        else $error("pair counter not zero while idle");

    // A pair taken before the final one means the render is still running.
    a_busy_mid_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !r_last_pair) |-> (r_state != ST_IDLE))
        else $error("sequencer idle with pairs outstanding");

    // A full, stalled output register holds the sequencer in emit.
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_out_valid && i_out_stall) |=> (r_state == ST_EMIT))
        else $error("pair emitted over a stalled result");

    // A render transaction starts the tile fetch in the next cycle.
    a_render_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        render_start |=> (r_state == ST_GFX && r_pos == '0))
        else $error("render did not start the sequencer");
`endif

endmodule

/* tb/tile_pair_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map renderer pair checker
// Shadows the graphics store, the palette and the settings, expands each
// accepted render transaction into its 32 pixel pairs and compares every
// accepted pair, field by field, with the oldest pair still outstanding.
// ----------------------------------------------------------------------------
module tile_pair_checker
    import tmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_screen_entry,
    input  logic [15:0] i_gfx_addr,
    input  logic [7:0]  i_gfx_byte,
    input  logic [7:0]  i_pal_index,
    input  logic [7:0]  i_pal_red,
    input  logic [7:0]  i_pal_green,
    input  logic [7:0]  i_pal_blue,
    // configuration channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_pixel_row,
    input  logic [1:0]  i_pair_column,
    input  logic [7:0]  i_left_red,
    input  logic [7:0]  i_left_green,
    input  logic [7:0]  i_left_blue,
    input  logic [7:0]  i_left_alpha,
    input  logic [7:0]  i_right_red,
    input  logic [7:0]  i_right_green,
    input  logic [7:0]  i_right_blue,
    input  logic [7:0]  i_right_alpha,
    input  logic        i_last_pair,
    // to the testbench top
    output int          o_mismatches,
    output int          o_outstanding
);

    localparam int REPORT_CAP = 60;

    // one RGBA pixel is {red, green, blue, alpha}
    typedef struct packed {
        logic [2:0]  row;
        logic [1:0]  col;
        logic [31:0] left;
        logic [31:0] right;
        logic        last;
    } pixel_pair_t;

    logic [7:0]  gfx_shadow [TILE_STORE_BYTES];
    logic [23:0] palette_shadow [PALETTE_ENTRIES];
    logic        single_palette_r = 1'b0;
    logic        eight_bpp_r      = 1'b0;
    logic        opaque_zero_r    = 1'b0;

    pixel_pair_t pending_pairs [$];
    int          fault_count = 0;
    int          pairs_seen  = 0;

    initial o_outstanding = 0;
    assign o_mismatches = fault_count;

    task automatic report_fault(string msg);
        // keep the log short on a badly broken block, but count everything
        if (fault_count < REPORT_CAP) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        fault_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            report_fault($sformatf("pair %0d %s = %0d, expected %0d",
                                   pairs_seen, name, got, want));
        end
    endtask

    function automatic logic [31:0] shade_pixel(logic [7:0] idx, logic [7:0] base);
        logic [7:0] slot;
        slot = base + idx;
        // transparency looks at the raw index, before the offset
        if (idx == 8'd0 && !opaque_zero_r) begin
            return 32'd0;
        end
        return {palette_shadow[slot], ALPHA_OPAQUE};
    endfunction

    task automatic expand_tile(logic [15:0] entry);
        logic [9:0]  tile_no;
        logic        hflip;
        logic        vflip;
        logic [7:0]  base;
        logic [2:0]  src_row;
        logic [1:0]  src_col;
        logic [7:0]  lpix;
        logic [7:0]  rpix;
        logic [7:0]  swap;
        logic [7:0]  packed_pair;
        int          addr;
        pixel_pair_t pair;
        tile_no = entry[9:0];
        hflip   = entry[10];
        vflip   = entry[11];
        base    = single_palette_r ? 8'd0 : {entry[15:12], 4'd0};
        for (int row = 0; row < 8; row++) begin
            for (int col = 0; col < 4; col++) begin
                src_row = vflip ? ~row[2:0] : row[2:0];
                src_col = hflip ? ~col[1:0] : col[1:0];
                if (eight_bpp_r) begin
                    addr = int'(tile_no) * 64 + int'(src_row) * 8 + int'(src_col) * 2;
                    lpix = gfx_shadow[addr % TILE_STORE_BYTES];
                    rpix = gfx_shadow[(addr + 1) % TILE_STORE_BYTES];
                end else begin
                    addr = int'(tile_no) * 32 + int'(src_row) * 4 + int'(src_col);
                    packed_pair = gfx_shadow[addr % TILE_STORE_BYTES];
                    lpix = packed_pair & LO_NIBBLE;
                    rpix = (packed_pair & HI_NIBBLE) >> 4;
                end
                if (hflip) begin
                    swap = lpix;
                    lpix = rpix;
                    rpix = swap;
                end
                pair.row   = row[2:0];
                pair.col   = col[1:0];
                pair.left  = shade_pixel(lpix, base);
                pair.right = shade_pixel(rpix, base);
                pair.last  = (row == 7 && col == 3);
                pending_pairs.push_back(pair);
            end
        end
    endtask

    task automatic check_pair();
        pixel_pair_t want;
        if (pending_pairs.size() == 0) begin
            report_fault($sformatf("pair at row %0d column %0d with nothing outstanding",
                                   i_pixel_row, i_pair_column));
            return;
        end
        want = pending_pairs.pop_front();
        check_field("pixel_row",     i_pixel_row,   want.row);
        check_field("pair_column",   i_pair_column, want.col);
        check_field("left_red",      i_left_red,    want.left[31:24]);
        check_field("left_green",    i_left_green,  want.left[23:16]);
        check_field("left_blue",     i_left_blue,   want.left[15:8]);
        check_field("left_alpha",    i_left_alpha,  want.left[7:0]);
        check_field("right_red",     i_right_red,   want.right[31:24]);
        check_field("right_green",   i_right_green, want.right[23:16]);
        check_field("right_blue",    i_right_blue,  want.right[15:8]);
        check_field("right_alpha",   i_right_alpha, want.right[7:0]);
        check_field("last_pair",     i_last_pair,   want.last);
        pairs_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_pairs.delete();
            single_palette_r = 1'b0;
            eight_bpp_r      = 1'b0;
            opaque_zero_r    = 1'b0;
        end else begin
            // results first, so a fresh render can never absorb a stray pair
            if (i_out_valid && !i_out_stall) begin
                check_pair();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SINGLE_PAL:  single_palette_r = i_cfg_data;
                    CFG_EIGHT_BPP:   eight_bpp_r      = i_cfg_data;
                    CFG_OPAQUE_ZERO: opaque_zero_r    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_req_type)
                    REQ_RENDER: expand_tile(i_screen_entry);
                    REQ_GFX_WR: gfx_shadow[int'(i_gfx_addr) % TILE_STORE_BYTES] = i_gfx_byte;
                    REQ_PAL_WR: palette_shadow[i_pal_index] =
                                    {i_pal_red, i_pal_green, i_pal_blue};
                    default: ;
                endcase
            end
        end
        o_outstanding <= pending_pairs.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile map pixel renderer testbench
// Loads the palette blocks of three palettes, runs a directed set of renders
// over flips, palettes and the tile extremes, then walks through every
// combination of the three settings with bursty random traffic: tile loads
// followed by renders, re-renders, palette rewrites, stray graphics writes
// and unused requests. A separate checker predicts and compares every pair.
// ----------------------------------------------------------------------------
module tb;
    import tmr_pkg::*;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         QUIET_CYCLES   = 16;
    localparam int         PHASE_ITEMS    = 9;
    localparam int         TILE_COUNT     = 1024;
    // 8bpp tiles hold indices up to this value, inside the loaded blocks
    localparam int         WIDE_INDEX_MAX = 31;
    localparam int         NEW_TILE_ODDS  = 20;

    // palettes that renders use; for each, two blocks of 16 entries are loaded
    localparam logic [3:0] PAL_LOW  = 4'd0;
    localparam logic [3:0] PAL_MID  = 4'd7;
    localparam logic [3:0] PAL_HIGH = 4'd15;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_RUNS
    } t_stall_mode;

    // every field of one request; unused fields still carry random data
    typedef struct {
        logic [1:0]  req;
        logic [15:0] entry;
        logic [15:0] addr;
        logic [7:0]  gfx_data;
        logic [7:0]  pal_slot;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_request;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type     = 2'd0;
    logic [15:0] screen_entry = 16'd0;
    logic [15:0] gfx_addr     = 16'd0;
    logic [7:0]  gfx_byte     = 8'd0;
    logic [7:0]  pal_index    = 8'd0;
    logic [7:0]  pal_red      = 8'd0;
    logic [7:0]  pal_green    = 8'd0;
    logic [7:0]  pal_blue     = 8'd0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = 2'd0;
    logic        cfg_data     = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [2:0]  pixel_row;
    logic [1:0]  pair_column;
    logic [7:0]  left_red;
    logic [7:0]  left_green;
    logic [7:0]  left_blue;
    logic [7:0]  left_alpha;
    logic [7:0]  right_red;
    logic [7:0]  right_green;
    logic [7:0]  right_blue;
    logic [7:0]  right_alpha;
    logic        last_pair;

    int          mismatches;
    int          pending;

    // Graphics bytes written so far: a render only ever touches these.
    bit          gfx_written [TILE_STORE_BYTES];
    // Written bytes that are also valid 8bpp indices inside the loaded blocks.
    bit          gfx_small [TILE_STORE_BYTES];
    bit          pal_written [PALETTE_ENTRIES];
    int          ready_narrow [$];
    int          ready_wide [$];
    bit          wide_mode   = 1'b0;
    int          items_sent  = 0;
    int          burst_left  = 0;

    // settings per phase as {single_palette, eight_bpp, opaque_zero}
    logic [2:0]  phase_cfg [8] = '{3'b000, 3'b111, 3'b010, 3'b101,
                                   3'b011, 3'b100, 3'b001, 3'b110};

    t_stall_mode stall_mode   = STALL_NONE;
    int          stretch_left = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tile_map_pixel_renderer uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_screen_entry (screen_entry),
        .i_gfx_addr     (gfx_addr),
        .i_gfx_byte     (gfx_byte),
        .i_pal_index    (pal_index),
        .i_pal_red      (pal_red),
        .i_pal_green    (pal_green),
        .i_pal_blue     (pal_blue),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_pixel_row    (pixel_row),
        .o_pair_column  (pair_column),
        .o_left_red     (left_red),
        .o_left_green   (left_green),
        .o_left_blue    (left_blue),
        .o_left_alpha   (left_alpha),
        .o_right_red    (right_red),
        .o_right_green  (right_green),
        .o_right_blue   (right_blue),
        .o_right_alpha  (right_alpha),
        .o_last_pair    (last_pair)
    );

    tile_pair_checker chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_screen_entry (screen_entry),
        .i_gfx_addr     (gfx_addr),
        .i_gfx_byte     (gfx_byte),
        .i_pal_index    (pal_index),
        .i_pal_red      (pal_red),
        .i_pal_green    (pal_green),
        .i_pal_blue     (pal_blue),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_pixel_row    (pixel_row),
        .i_pair_column  (pair_column),
        .i_left_red     (left_red),
        .i_left_green   (left_green),
        .i_left_blue    (left_blue),
        .i_left_alpha   (left_alpha),
        .i_right_red    (right_red),
        .i_right_green  (right_green),
        .i_right_blue   (right_blue),
        .i_right_alpha  (right_alpha),
        .i_last_pair    (last_pair),
        .o_mismatches   (mismatches),
        .o_outstanding  (pending)
    );

    // Result side: pick a stall style for a stretch of cycles, then move on.
    // The run style toggles rarely, which gives long holds and long free runs.
    always @(posedge clk) begin
        if (stretch_left == 0) begin
            stall_mode   <= t_stall_mode'($urandom_range(0, 3));
            stretch_left <= $urandom_range(20, 200);
        end else begin
            stretch_left <= stretch_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if ($urandom_range(0, 15) == 0) begin
                    out_stall <= !out_stall;
                end
            end
        endcase
    end

    function automatic t_request random_request(logic [1:0] req);
        t_request r;
        r.req      = req;
        r.entry    = $urandom_range(0, 65535);
        r.addr     = $urandom_range(0, 65535);
        r.gfx_data = $urandom_range(0, 255);
        r.pal_slot = $urandom_range(0, 255);
        r.red      = $urandom_range(0, 255);
        r.green    = $urandom_range(0, 255);
        r.blue     = $urandom_range(0, 255);
        return r;
    endfunction

    function automatic logic [3:0] pick_palette();
        case ($urandom_range(0, 2))
            0:       return PAL_LOW;
            1:       return PAL_MID;
            default: return PAL_HIGH;
        endcase
    endfunction

    // Present one transaction and hold it until it is taken. Bursts end with
    // a gap in which valid is low, so valid is never dropped and raised in
    // the same step.
    task automatic send_item(t_request r);
        req_type     <= r.req;
        screen_entry <= r.entry;
        gfx_addr     <= r.addr;
        gfx_byte     <= r.gfx_data;
        pal_index    <= r.pal_slot;
        pal_red      <= r.red;
        pal_green    <= r.green;
        pal_blue     <= r.blue;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (r.req != REQ_UNUSED) begin
            items_sent++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic write_gfx(int addr, logic [7:0] value);
        t_request r;
        r          = random_request(REQ_GFX_WR);
        r.addr     = addr;
        r.gfx_data = value;
        gfx_written[addr % TILE_STORE_BYTES] = 1'b1;
        gfx_small[addr % TILE_STORE_BYTES]   = (value <= WIDE_INDEX_MAX);
        send_item(r);
    endtask

    task automatic write_palette(int slot, logic [23:0] colour);
        t_request r;
        r          = random_request(REQ_PAL_WR);
        r.pal_slot = slot;
        {r.red, r.green, r.blue} = colour;
        send_item(r);
    endtask

    // Load the entries that a palette can reach: 16 in 4bpp, 32 in 8bpp
    // bench tiles, wrapping past the palette top for the highest one.
    task automatic load_palette_block(logic [3:0] pal);
        int          slot;
        logic [23:0] colour;
        for (int k = 0; k <= WIDE_INDEX_MAX; k++) begin
            slot = (int'(pal) * 16 + k) % PALETTE_ENTRIES;
            if (!pal_written[slot]) begin
                if (slot == 0) begin
                    colour = 24'h000000;
                end else if (slot == PALETTE_ENTRIES - 1) begin
                    colour = 24'hFFFFFF;
                end else begin
                    colour = $urandom_range(0, 24'hFFFFFF);
                end
                pal_written[slot] = 1'b1;
                write_palette(slot, colour);
            end
        end
    endtask

    task automatic render(logic [15:0] entry);
        t_request r;
        r       = random_request(REQ_RENDER);
        r.entry = entry;
        send_item(r);
    endtask

    function automatic bit tile_ready(int tile_no, bit wide);
        int span;
        int a;
        span = wide ? 64 : 32;
        for (int k = 0; k < span; k++) begin
            a = (tile_no * span + k) % TILE_STORE_BYTES;
            if (!gfx_written[a] || (wide && !gfx_small[a])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Fill a whole tile, forwards or backwards. Narrow tiles mix random
    // bytes with bytes that force index zero and index fifteen; wide tiles
    // keep their indices inside the loaded palette blocks.
    task automatic load_tile(int tile_no, bit wide);
        int         span;
        int         off;
        bit         backwards;
        logic [7:0] value;
        span      = wide ? 64 : 32;
        backwards = $urandom_range(0, 1);
        for (int k = 0; k < span; k++) begin
            off = backwards ? span - 1 - k : k;
            if (wide) begin
                case ($urandom_range(0, 3))
                    0:       value = 8'h00;
                    1:       value = 8'(WIDE_INDEX_MAX);
                    default: value = 8'($urandom_range(0, WIDE_INDEX_MAX));
                endcase
            end else begin
                case ($urandom_range(0, 7))
                    0:       value = 8'h00;
                    1:       value = 8'hFF;
                    2:       value = {4'h0, 4'($urandom_range(0, 15))};
                    3:       value = {4'($urandom_range(0, 15)), 4'h0};
                    default: value = $urandom_range(0, 255);
                endcase
            end
            write_gfx((tile_no * span + off) % TILE_STORE_BYTES, value);
        end
        if (wide) begin
            ready_wide.push_back(tile_no);
            // a wide tile in the lower half also covers two narrow tiles
            if (tile_no < TILE_COUNT / 2) begin
                ready_narrow.push_back(2 * tile_no);
                ready_narrow.push_back(2 * tile_no + 1);
            end
        end else begin
            ready_narrow.push_back(tile_no);
        end
    endtask

    // Drop valid, wait for every pair to drain, then let any write or
    // ignored transaction still in flight finish.
    task automatic settle(int quiet);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (quiet) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_settings(logic [2:0] bits);
        settle(QUIET_CYCLES);
        cfg_write(CFG_SINGLE_PAL, bits[2]);
        cfg_write(CFG_EIGHT_BPP, bits[1]);
        cfg_write(CFG_OPAQUE_ZERO, bits[0]);
        cfg_valid <= 1'b0;
        wide_mode = bits[1];
    endtask

    // Mostly re-renders of loaded tiles with random flips and one of the
    // loaded palettes, now and then a freshly loaded tile; the rest is
    // palette rewrites, stray graphics writes anywhere in the store and
    // unused request codes.
    task automatic random_phase(int quota);
        int         first;
        int         roll;
        int         tile_no;
        logic [15:0] entry;
        first = items_sent;
        while (items_sent - first < quota) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                send_item(random_request(REQ_PAL_WR));
            end else if (roll < 16) begin
                write_gfx($urandom_range(0, 65535), $urandom_range(0, 255));
            end else if (roll < 19) begin
                send_item(random_request(REQ_UNUSED));
            end else begin
                if (wide_mode && ready_wide.size() > 0) begin
                    tile_no = ready_wide[$urandom_range(0, ready_wide.size() - 1)];
                end else if (!wide_mode && ready_narrow.size() > 0 &&
                             $urandom_range(1, NEW_TILE_ODDS) != 1) begin
                    tile_no = ready_narrow[$urandom_range(0, ready_narrow.size() - 1)];
                end else begin
                    tile_no = $urandom_range(0, TILE_COUNT - 1);
                end
                if (!tile_ready(tile_no, wide_mode)) begin
                    load_tile(tile_no, wide_mode);
                end
                entry        = $urandom_range(0, 65535);
                entry[9:0]   = tile_no[9:0];
                entry[15:12] = pick_palette();
                render(entry);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every palette entry that a render can reach, so no render
        // reads an unwritten one; the first and last entries take the
        // extreme colours.
        load_palette_block(PAL_LOW);
        load_palette_block(PAL_MID);
        load_palette_block(PAL_HIGH);

        // Directed part at reset settings: tile 0 holds every nibble value
        // on both sides, tile 1023 is random; render with no flip, each
        // flip, both flips, the lowest and highest palettes.
        for (int i = 0; i < 32; i++) begin
            write_gfx(i, {i[3:0], ~i[3:0]});
        end
        ready_narrow.push_back(0);
        load_tile(TILE_COUNT - 1, 1'b0);
        write_gfx(16'hFFFF, 8'hA5);
        render(16'h0000);
        render(16'h0400);
        render(16'h0800);
        render(16'h0C00);
        render(16'hF000);
        render(16'h73FF);
        render(16'hFFFF);
        send_item(random_request(REQ_UNUSED));

        // Walk through every combination of the settings.
        for (int p = 0; p < 8; p++) begin
            apply_settings(phase_cfg[p]);
            random_phase(PHASE_ITEMS);
        end

        settle(4 * QUIET_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/tmr_pkg.sv
rtl/tmr_ram.sv
rtl/tmr_shade_unit.sv
rtl/tile_map_pixel_renderer.sv
tb/tile_pair_checker.sv
tb/tb.sv
